FILE: sv/indexed_list_store_core_assert.svh
// Assertion macros used by the checker of the indexed list store.
`ifndef INDEXED_LIST_STORE_CORE_ASSERT_SVH
`define INDEXED_LIST_STORE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ILS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ils_pkg.sv
// Package of the indexed list store: field widths, operation and status codes.
package ils_pkg;

  localparam int FUNC_W   = 3;
  localparam int POS_W    = 4;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND    = 3'd0,
    FN_INSERT    = 3'd1,
    FN_OVERWRITE = 3'd2,
    FN_REMOVE    = 3'd3,
    FN_READ      = 3'd4,
    FN_CLEAR     = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_BADOP = 2'd3
  } status_t;

  // Command that every cell obeys: hold, write, insert or remove.
  typedef enum logic [1:0] {
    CO_HOLD,
    CO_WRITE,
    CO_INSERT,
    CO_REMOVE
  } cell_op_t;

  // Decoded request, from the controller to the top level.
  typedef struct packed {
    cell_op_t op;
    status_t  status;
    logic     rd_hit;
  } ctl_t;

endpackage

FILE: sv/ils_if.sv
// Request and response channel interfaces of the indexed list store.
interface ils_req_if;
  logic                        valid;
  logic                        ready;
  logic [ils_pkg::FUNC_W-1:0]  func;
  logic [ils_pkg::POS_W-1:0]   position;
  logic [ils_pkg::DATA_W-1:0]  word_in;

  modport source (output valid, output func, output position, output word_in, input ready);
  modport sink (input valid, input func, input position, input word_in, output ready);
endinterface

interface ils_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ils_pkg::STATUS_W-1:0]  status;
  logic [ils_pkg::DATA_W-1:0]    word_out;
  logic [ils_pkg::USED_W-1:0]    entries_used;

  modport source (output valid, output status, output word_out, output entries_used,
                  input ready);
  modport sink (input valid, input status, input word_out, input entries_used,
                output ready);
endinterface

FILE: sv/ils_cell.sv
// One storage cell of the list: holds a word, loads it or takes a neighbour's.
module ils_cell #(
  parameter int WORD_WIDTH = 32,
  parameter int CMP_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  ils_pkg::cell_op_t     op,
  input  logic [CMP_W-1:0]      target,
  input  logic [WORD_WIDTH-1:0] word,
  input  logic [WORD_WIDTH-1:0] lower,
  input  logic [WORD_WIDTH-1:0] upper,
  output logic [WORD_WIDTH-1:0] q
);

  localparam logic [CMP_W-1:0] MY_INDEX = CMP_W'(INDEX);

  logic [WORD_WIDTH-1:0] q_next;

  always_comb begin
    q_next = q;
    case (op)
      ils_pkg::CO_WRITE: begin
        if (MY_INDEX == target) q_next = word;
      end
      ils_pkg::CO_INSERT: begin
        // open a gap at the target: everything above moves up one place
        if (MY_INDEX == target) q_next = word;
        else if (MY_INDEX > target) q_next = lower;
      end
      ils_pkg::CO_REMOVE: begin
        // close the gap: take the word from the cell above
        if (MY_INDEX >= target) q_next = upper;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: sv/ils_ctrl.sv
// Request decoder: range and full checks, next count and the command for the cells.
module ils_ctrl #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5,
  parameter int CMP_W = 5
) (
  input  logic [ils_pkg::FUNC_W-1:0] func,
  input  logic [CMP_W-1:0]           pos_x,
  input  logic [CNT_W-1:0]           count,
  input  logic                       accept,
  output ils_pkg::ctl_t              ctl,
  output logic [CMP_W-1:0]           target,
  output logic [CNT_W-1:0]           count_next
);

  localparam logic [CMP_W-1:0] FULL_MARK = CMP_W'(DEPTH);

  logic [CMP_W-1:0]  cnt_x;
  logic              full;
  ils_pkg::cell_op_t op_raw;

  assign cnt_x = CMP_W'(count);
  assign full  = (cnt_x == FULL_MARK);

  always_comb begin
    op_raw         = ils_pkg::CO_HOLD;
    ctl.status     = ils_pkg::ST_OK;
    ctl.rd_hit     = 1'b0;
    target         = pos_x;
    count_next     = count;
    case (func)
      ils_pkg::FN_APPEND: begin
        if (full) begin
          ctl.status = ils_pkg::ST_FULL;
        end else begin
          op_raw     = ils_pkg::CO_WRITE;
          target     = cnt_x;
          count_next = CNT_W'(count + 1'b1);
        end
      end
      ils_pkg::FN_INSERT: begin
        // index is checked before fullness
        if (pos_x > cnt_x) begin
          ctl.status = ils_pkg::ST_RANGE;
        end else if (full) begin
          ctl.status = ils_pkg::ST_FULL;
        end else begin
          op_raw     = ils_pkg::CO_INSERT;
          count_next = CNT_W'(count + 1'b1);
        end
      end
      ils_pkg::FN_OVERWRITE: begin
        if (pos_x >= cnt_x) ctl.status = ils_pkg::ST_RANGE;
        else op_raw = ils_pkg::CO_WRITE;
      end
      ils_pkg::FN_REMOVE: begin
        if (pos_x >= cnt_x) begin
          ctl.status = ils_pkg::ST_RANGE;
        end else begin
          op_raw     = ils_pkg::CO_REMOVE;
          count_next = CNT_W'(count - 1'b1);
        end
      end
      ils_pkg::FN_READ: begin
        if (pos_x >= cnt_x) ctl.status = ils_pkg::ST_RANGE;
        else ctl.rd_hit = 1'b1;
      end
      ils_pkg::FN_CLEAR: begin
        count_next = '0;
      end
      default: begin
        ctl.status = ils_pkg::ST_BADOP;
      end
    endcase
    // cells move only on an accepted transaction
    ctl.op = accept ? op_raw : ils_pkg::CO_HOLD;
  end

endmodule

FILE: sv/indexed_list_store_core.sv
// Indexed list store: an ordered list of up to DEPTH words held in a row of cells.
// Each request transaction carries an operation (append, insert, overwrite, remove,
// read or clear), an index and a word, and produces exactly one response transaction
// with a status, the word read (zero unless a read succeeds) and the count of entries
// afterwards. The row of cells shifts all later entries up or down as the request is
// accepted, so a new request is taken in every cycle in which the response register is
// empty or being drained, and the response is registered and appears in the cycle after
// acceptance. Only entries below the count are ever read; the cells are not
// cleared by reset or by a clear request. Stored words are WORD_WIDTH bits wide, taken
// from the low bits of word_in and zero-extended or cut to 32 bits on read-out.

module indexed_list_store_core #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  ils_req_if.sink         req,
  ils_rsp_if.source       rsp
);

  // count must hold DEPTH itself; compares run wide enough for both count and index
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > ils_pkg::POS_W) ? CNT_W : ils_pkg::POS_W;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      target;
  logic                  accept;
  ils_pkg::ctl_t         ctl;

  logic [63:0]           word_wide;
  logic [WORD_WIDTH-1:0] word_st;
  logic [WORD_WIDTH-1:0] cell_q [DEPTH];
  logic [WORD_WIDTH-1:0] rd_word;
  logic [63:0]           rd_wide;
  logic [31:0]           count_wide;

  // response register
  logic                           rsp_valid;
  logic [ils_pkg::STATUS_W-1:0]   status;
  logic [ils_pkg::DATA_W-1:0]     word_out;
  logic [ils_pkg::USED_W-1:0]     entries_used;

  // take a new transaction whenever the response slot is free or being emptied
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign pos_x     = CMP_W'(req.position);
  assign word_wide = 64'(req.word_in);
  assign word_st   = word_wide[WORD_WIDTH-1:0];

  ils_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .CMP_W (CMP_W)
  ) u_ctrl (
    .func       (req.func),
    .pos_x      (pos_x),
    .count      (count),
    .accept     (accept),
    .ctl        (ctl),
    .target     (target),
    .count_next (count_next)
  );

  // Row of cells: each sees its neighbours, so insert and remove shift the row at once.
  // The bottom cell has no lower neighbour and the top cell none above; feed them
  // something harmless, never selected or landing beyond the count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] lower;
    logic [WORD_WIDTH-1:0] upper;

    if (i == 0) begin : g_bottom
      assign lower = word_st;
    end else begin : g_lower
      assign lower = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign upper = cell_q[i];
    end else begin : g_upper
      assign upper = cell_q[i+1];
    end

    ils_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .CMP_W      (CMP_W),
      .INDEX      (i)
    ) u_cell (
      .clk    (clk),
      .op     (ctl.op),
      .target (target),
      .word   (word_st),
      .lower  (lower),
      .upper  (upper),
      .q      (cell_q[i])
    );
  end

  // Read port: pick the addressed cell; zero unless the read is in range.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ctl.rd_hit && (pos_x == CMP_W'(i))) rd_word = cell_q[i];
    end
  end

  assign rd_wide    = 64'(rd_word);
  assign count_wide = 32'(count_next);

  // Count: cleared by reset, loaded with the next count on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Response valid: set on acceptance, dropped once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload: load on acceptance, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= ctl.status;
      word_out     <= rd_wide[ils_pkg::DATA_W-1:0];
      entries_used <= count_wide[ils_pkg::USED_W-1:0];
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = status;
  assign rsp.word_out     = word_out;
  assign rsp.entries_used = entries_used;

endmodule

FILE: sv/ils_checker.sv
// Port-level checker of the indexed list store and its bind to the top level.
`include "indexed_list_store_core_assert.svh"

module ils_checker #(
  parameter int DEPTH = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [ils_pkg::STATUS_W-1:0]  status,
  input logic [ils_pkg::DATA_W-1:0]    word_out,
  input logic [ils_pkg::USED_W-1:0]    entries_used
);

  localparam logic [ils_pkg::USED_W-1:0] FULL_USED = ils_pkg::USED_W'(DEPTH);

  // every accepted request gives a response in the next cycle
  `ILS_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, rsp_valid, "no response after request")

  // a stalled response holds its payload
  `ILS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
    rsp_valid && $stable(status) && $stable(word_out) && $stable(entries_used),
    "stalled response changed")

  // only a successful read carries a word
  `ILS_ASSERT_NOW(a_word_zero, rsp_valid && (status != ils_pkg::ST_OK), word_out == '0,
    "failed request returned a non-zero word")

  // a full status means the list really is at capacity
  `ILS_ASSERT_NOW(a_full_count, rsp_valid && (status == ils_pkg::ST_FULL),
    entries_used == FULL_USED, "full status with spare capacity")

endmodule

bind indexed_list_store_core ils_checker #(
  .DEPTH (DEPTH)
) u_ils_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .word_out     (rsp.word_out),
  .entries_used (rsp.entries_used)
);
